@@ src/fspa_pkg.sv @@
// Package for the fixed slot pool allocator: sizes, op and register codes,
// and the command struct passed from the control to the totals unit.
// No dependencies.
package fspa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int LINK_W    = SLOT_W + 1;
  localparam int ADDR_W    = 32;
  localparam int OBJ_W     = 16;
  localparam int COUNT_W   = 11;
  localparam int PROD_W    = SLOT_W + OBJ_W;
  localparam int TOTAL_W   = 27;
  localparam int BYTES_W   = 26;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 112;

  localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(MAX_SLOTS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_SLOT_BYTES  = 2'd1,
    CFG_SLOT_COUNT  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } stats_cmd_t;

endpackage

@@ src/fspa_link_ram.sv @@
// Link memory: one next-slot link per slot, one write and one read port,
// read data registered. Depends on fspa_pkg.
module fspa_link_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [fspa_pkg::SLOT_W-1:0]   waddr,
  input  logic [fspa_pkg::LINK_W-1:0]   wdata,
  input  logic                          re,
  input  logic [fspa_pkg::SLOT_W-1:0]   raddr,
  output logic [fspa_pkg::LINK_W-1:0]   rdata
);

  logic [fspa_pkg::LINK_W-1:0] mem [fspa_pkg::MAX_SLOTS];
  logic [fspa_pkg::LINK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/fspa_stats.sv @@
// Running totals: used bytes, peak bytes and live slot count, with
// saturation. Depends on fspa_pkg.
module fspa_stats (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fspa_pkg::stats_cmd_t            cmd,
  input  logic [fspa_pkg::OBJ_W-1:0]      slot_bytes,
  output logic [fspa_pkg::BYTES_W-1:0]    used_bytes,
  output logic [fspa_pkg::BYTES_W-1:0]    peak_bytes,
  output logic [fspa_pkg::COUNT_W-1:0]    live_count
);

  localparam logic [fspa_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [fspa_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [fspa_pkg::BYTES_W-1:0] BYTES_MAX = '1;

  logic [fspa_pkg::TOTAL_W-1:0] used_r, used_nxt;
  logic [fspa_pkg::TOTAL_W-1:0] peak_r, peak_nxt;
  logic [fspa_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [fspa_pkg::TOTAL_W:0]   sum;
  logic [fspa_pkg::TOTAL_W-1:0] obj_ext;

  always_comb begin
    obj_ext   = fspa_pkg::TOTAL_W'(slot_bytes);
    sum       = {1'b0, used_r} + {1'b0, obj_ext};
    used_nxt  = used_r;
    peak_nxt  = peak_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      used_nxt  = '0;
      peak_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.add) begin
      used_nxt = sum[fspa_pkg::TOTAL_W] ? TOTAL_MAX : sum[fspa_pkg::TOTAL_W-1:0];
      if (used_nxt > peak_r) begin
        peak_nxt = used_nxt;
      end
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end else if (cmd.sub) begin
      used_nxt = (used_r >= obj_ext) ? used_r - obj_ext : '0;
      if (count_r != '0) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      peak_r  <= '0;
      count_r <= '0;
    end else begin
      used_r  <= used_nxt;
      peak_r  <= peak_nxt;
      count_r <= count_nxt;
    end
  end

  assign used_bytes = used_r[fspa_pkg::TOTAL_W-1] ? BYTES_MAX
                                                  : used_r[fspa_pkg::BYTES_W-1:0];
  assign peak_bytes = peak_r[fspa_pkg::TOTAL_W-1] ? BYTES_MAX
                                                  : peak_r[fspa_pkg::BYTES_W-1:0];
  assign live_count = count_r;

endmodule

@@ src/fixed_slot_pool_allocator.sv @@
// Top level of the fixed slot pool allocator: free-list control, config
// registers and result register. Depends on fspa_pkg, fspa_link_ram and
// fspa_stats.
//
//   channel | direction | tdata / data                    | tuser
//   in_     | slave     | [9:0] slot_index                | [1:0] op
//   out_    | master    | slot, address, used, peak, live | [0] ok
//   cfg_    | slave     | cfg_index selects, cfg_data     | -
//
// One item at a time; in_tready returns as the result loads. An allocate from
// a non-empty list passes ST_EXEC (link read), ST_RD (the address multiply)
// and ST_FIN; any other allocate, a free or a no-op passes ST_EXEC and ST_FIN;
// a clear passes ST_EXEC, ST_SWEEP (one link written per cycle up to the
// effective slot_count) and ST_FIN, where an unread result stalls the load.
// Synchronous active-low reset; links are undefined until a clear or free.
module fixed_slot_pool_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fspa_pkg::IN_DATA_W-1:0]      in_tdata,  // [9:0] slot_index
  input  logic [1:0]                          in_tuser,  // [1:0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] given_slot, [41:10] address, [67:42] used_bytes,
  // [93:68] peak_bytes, [104:94] live_count
  output logic [fspa_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [0:0]                          out_tuser, // [0] ok
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_RD    = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  localparam int SW = fspa_pkg::SLOT_W;
  localparam int LW = fspa_pkg::LINK_W;

  state_t state_r, state_nxt;

  logic [fspa_pkg::ADDR_W-1:0]  pool_base_r;
  logic [fspa_pkg::OBJ_W-1:0]   slot_bytes_r;
  logic [fspa_pkg::COUNT_W-1:0] slot_count_r;

  fspa_pkg::op_t   op_r, op_nxt;
  logic [SW-1:0]   idx_r, idx_nxt;
  logic [LW-1:0]   head_r, head_nxt;
  logic [SW-1:0]   sweep_r, sweep_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [fspa_pkg::PROD_W-1:0] prod_r;
  logic            res_ok_r, res_ok_nxt;
  logic            res_alloc_r, res_alloc_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [fspa_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_ok_r, out_ok_nxt;

  logic            in_fire;
  logic            out_load;
  logic [LW-1:0]   eff_count;
  logic [SW-1:0]   last_slot;
  logic            sweep_last;

  logic            ram_we, ram_re;
  logic [SW-1:0]   ram_waddr, ram_raddr;
  logic [LW-1:0]   ram_wdata, ram_rdata;

  fspa_pkg::stats_cmd_t         stats_cmd;
  logic [fspa_pkg::BYTES_W-1:0] used_bytes, peak_bytes;
  logic [fspa_pkg::COUNT_W-1:0] live_count;
  logic [fspa_pkg::ADDR_W-1:0]  res_addr;
  logic [SW-1:0]                res_slot;

  fspa_link_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fspa_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (stats_cmd),
    .slot_bytes  (slot_bytes_r),
    .used_bytes  (used_bytes),
    .peak_bytes  (peak_bytes),
    .live_count  (live_count)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    if (slot_count_r == '0) begin
      eff_count = LW'(1);
    end else if (32'(slot_count_r) > 32'(fspa_pkg::MAX_SLOTS)) begin
      eff_count = LW'(fspa_pkg::MAX_SLOTS);
    end else begin
      eff_count = LW'(slot_count_r);
    end
  end

  assign last_slot  = SW'(eff_count - LW'(1));
  assign sweep_last = (sweep_r == last_slot);

  assign res_addr = res_alloc_r ? pool_base_r + fspa_pkg::ADDR_W'(prod_r) : '0;
  assign res_slot = res_alloc_r ? slot_r : '0;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    sweep_nxt     = sweep_r;
    slot_nxt      = slot_r;
    res_ok_nxt    = res_ok_r;
    res_alloc_nxt = res_alloc_r;
    ram_we        = 1'b0;
    ram_waddr     = sweep_r;
    ram_wdata     = head_r;
    ram_re        = 1'b0;
    ram_raddr     = head_r[SW-1:0];
    stats_cmd     = '0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = fspa_pkg::op_t'(in_tuser);
          idx_nxt   = in_tdata[SW-1:0];
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ok_nxt    = 1'b0;
        res_alloc_nxt = 1'b0;
        state_nxt     = ST_FIN;
        case (op_r)
          fspa_pkg::OP_ALLOC: begin
            if (head_r < fspa_pkg::NULL_SLOT) begin
              ram_re    = 1'b1;
              slot_nxt  = head_r[SW-1:0];
              state_nxt = ST_RD;
            end
          end
          fspa_pkg::OP_FREE: begin
            if ({1'b0, idx_r} < eff_count) begin
              ram_we        = 1'b1;
              ram_waddr     = idx_r;
              ram_wdata     = head_r;
              head_nxt      = {1'b0, idx_r};
              res_ok_nxt    = 1'b1;
              stats_cmd.sub = 1'b1;
            end
          end
          fspa_pkg::OP_CLEAR: begin
            sweep_nxt = '0;
            state_nxt = ST_SWEEP;
          end
          default: begin
          end
        endcase
      end
      ST_RD: begin
        head_nxt      = (ram_rdata > fspa_pkg::NULL_SLOT) ? fspa_pkg::NULL_SLOT
                                                          : ram_rdata;
        res_ok_nxt    = 1'b1;
        res_alloc_nxt = 1'b1;
        stats_cmd.add = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = sweep_last ? fspa_pkg::NULL_SLOT : LW'(sweep_r) + LW'(1);
        if (sweep_last) begin
          head_nxt        = '0;
          stats_cmd.clear = 1'b1;
          res_ok_nxt      = 1'b1;
          state_nxt       = ST_FIN;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok_r;
      out_data_nxt  = fspa_pkg::OUT_DATA_W'({live_count, peak_bytes, used_bytes,
                                             res_addr, res_slot});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= fspa_pkg::NULL_SLOT;
      out_valid_r   <= 1'b0;
      pool_base_r   <= '0;
      slot_bytes_r  <= fspa_pkg::OBJ_W'(1);
      slot_count_r  <= fspa_pkg::COUNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (fspa_pkg::cfg_idx_t'(cfg_index))
          fspa_pkg::CFG_POOL_BASE:  pool_base_r  <= cfg_data;
          fspa_pkg::CFG_SLOT_BYTES: slot_bytes_r <= cfg_data[fspa_pkg::OBJ_W-1:0];
          fspa_pkg::CFG_SLOT_COUNT: slot_count_r <= cfg_data[fspa_pkg::COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    sweep_r     <= sweep_nxt;
    slot_r      <= slot_nxt;
    res_ok_r    <= res_ok_nxt;
    res_alloc_r <= res_alloc_nxt;
    out_data_r  <= out_data_nxt;
    out_ok_r    <= out_ok_nxt;
    if (state_r == ST_RD) begin
      prod_r <= fspa_pkg::PROD_W'(slot_r) * fspa_pkg::PROD_W'(slot_bytes_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

endmodule

@@ src/fspa_chk.sv @@
// Port-level checker for fixed_slot_pool_allocator, bound to the top level.
// Depends on fspa_pkg.
module fspa_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fspa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[41:0] == 42'd0)
    else $error("failed item carries slot or address");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[67:42] <= out_tdata[93:68])
    else $error("used bytes above peak bytes");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind fixed_slot_pool_allocator fspa_chk u_fspa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/tb_fixed_slot_pool_allocator.sv @@
// Self-checking testbench for fixed_slot_pool_allocator: pool ops go in on in_,
// each result on out_ is checked against a free-list predictor kept in the bench.
// Depends on fspa_pkg and the allocator RTL.
module tb_fixed_slot_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 70;
  localparam int PHASES       = 5;
  localparam int LOOP_ALLOCS  = 60;

  typedef struct packed {
    fspa_pkg::op_t op;
    logic        ok;
    logic [9:0]  slot;
    logic [31:0] addr;
    logic [25:0] used;
    logic [25:0] peak;
    logic [10:0] live;
  } pool_reply_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [fspa_pkg::IN_DATA_W-1:0]    in_tdata   = '0;
  logic [1:0]                        in_tuser   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [fspa_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic [0:0]                        out_tuser;
  logic                              cfg_valid  = 1'b0;
  logic                              cfg_ready;
  logic [fspa_pkg::CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [31:0]                       cfg_data   = '0;

  // predictor state
  logic [31:0]  cfg_base  = '0;
  logic [15:0]  cfg_obj   = 16'd1;
  logic [10:0]  cfg_slots = 11'd1;
  logic [10:0]  free_head = fspa_pkg::NULL_SLOT;
  logic [10:0]  link_mem [fspa_pkg::MAX_SLOTS];
  logic [26:0]  used_sum  = '0;
  logic [26:0]  peak_sum  = '0;
  logic [10:0]  live_slots = '0;

  pool_reply_t  alloc_replies [$];
  pool_reply_t  want;
  logic [9:0]   held_slots [$];

  int  fail_cnt     = 0;
  int  ops_sent     = 0;
  int  replies_seen = 0;
  int  grants       = 0;
  int  refusals     = 0;
  int  quiet_cycles = 0;
  int  ready_hold   = 0;
  bit  idle_on      = 1'b1;

  fixed_slot_pool_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (link_mem[i]) link_mem[i] = '0;
  end

  function automatic int usable_slots();
    int n;
    n = int'(cfg_slots);
    if (n == 0) n = 1;
    if (n > fspa_pkg::MAX_SLOTS) n = fspa_pkg::MAX_SLOTS;
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one op to the free-list state and returns the reply it yields.
  function automatic pool_reply_t pool_reply(fspa_pkg::op_t op, logic [9:0] idx);
    pool_reply_t r;
    logic [9:0]  s;
    logic [27:0] sum;
    int          n;
    r    = '0;
    r.op = op;
    n    = usable_slots();
    case (op)
      fspa_pkg::OP_ALLOC: begin
        if (free_head < fspa_pkg::NULL_SLOT) begin
          s         = free_head[9:0];
          free_head = link_mem[s];
          if (free_head > fspa_pkg::NULL_SLOT) free_head = fspa_pkg::NULL_SLOT;
          r.ok   = 1'b1;
          r.slot = s;
          r.addr = cfg_base + 32'(s) * 32'(cfg_obj);
          sum      = {1'b0, used_sum} + 28'(cfg_obj);
          used_sum = sum[27] ? '1 : sum[26:0];
          if (used_sum > peak_sum) peak_sum = used_sum;
          if (live_slots != '1) live_slots = live_slots + 1'b1;
        end
      end
      fspa_pkg::OP_FREE: begin
        if (int'(idx) < n) begin
          link_mem[idx] = free_head;
          free_head     = {1'b0, idx};
          r.ok          = 1'b1;
          used_sum = (used_sum >= 27'(cfg_obj)) ? used_sum - 27'(cfg_obj) : '0;
          if (live_slots != 0) live_slots = live_slots - 1'b1;
        end
      end
      fspa_pkg::OP_CLEAR: begin
        for (int i = 0; i < n - 1; i++) link_mem[i] = 11'(i + 1);
        link_mem[n-1] = fspa_pkg::NULL_SLOT;
        free_head  = '0;
        used_sum   = '0;
        peak_sum   = '0;
        live_slots = '0;
        r.ok       = 1'b1;
      end
      default: ;
    endcase
    r.used = used_sum[26] ? '1 : used_sum[25:0];
    r.peak = peak_sum[26] ? '1 : peak_sum[25:0];
    r.live = live_slots;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // input side: predict at accept
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      alloc_replies.push_back(pool_reply(fspa_pkg::op_t'(in_tuser), in_tdata[9:0]));
      ops_sent++;
    end
  end

  // register writes
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (fspa_pkg::cfg_idx_t'(cfg_index))
        fspa_pkg::CFG_POOL_BASE:  cfg_base  = cfg_data;
        fspa_pkg::CFG_SLOT_BYTES: cfg_obj   = cfg_data[15:0];
        fspa_pkg::CFG_SLOT_COUNT: cfg_slots = cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (alloc_replies.size() == 0) begin
        $error("result item with no prediction outstanding");
        fail_cnt++;
      end else begin
        want = alloc_replies.pop_front();
        check_field("ok",         want.ok,   out_tuser[0]);
        check_field("given_slot", want.slot, out_tdata[9:0]);
        check_field("address",    want.addr, out_tdata[41:10]);
        check_field("used_bytes", want.used, out_tdata[67:42]);
        check_field("peak_bytes", want.peak, out_tdata[93:68]);
        check_field("live_count", want.live, out_tdata[104:94]);
        if (want.op == fspa_pkg::OP_ALLOC) begin
          if (want.ok) begin
            grants++;
            held_slots.push_back(want.slot);
          end else begin
            refusals++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic issue_op(fspa_pkg::op_t op, logic [9:0] idx);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(fspa_pkg::IN_DATA_W-10){1'b0}}, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (alloc_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(fspa_pkg::cfg_idx_t idx, logic [31:0] val, bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // upper data bits carry junk the block must ignore; the unused index is
  // written last and must change nothing
  task automatic set_pool(logic [31:0] base, logic [15:0] obj, logic [10:0] slots);
    settle();
    cfg_write(fspa_pkg::CFG_POOL_BASE, base, 1'b1);
    cfg_write(fspa_pkg::CFG_SLOT_BYTES, {16'($urandom), obj}, 1'b1);
    cfg_write(fspa_pkg::CFG_SLOT_COUNT, {21'($urandom), slots}, 1'b1);
    cfg_write(fspa_pkg::CFG_UNUSED, $urandom, 1'b0);
  endtask

  task automatic test_reset_state();
    issue_op(fspa_pkg::OP_ALLOC, 10'h3FF);  // list still null after reset
    issue_op(fspa_pkg::OP_NOP, 10'h155);
    issue_op(fspa_pkg::OP_FREE, 10'd1);     // beyond slot count
    issue_op(fspa_pkg::OP_FREE, 10'd0);     // free without allocate
    issue_op(fspa_pkg::OP_ALLOC, 10'h2AA);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
  endtask

  task automatic test_register_extremes();
    set_pool(32'hFFFF_FFF0, 16'hFFFF, 11'd0);
    issue_op(fspa_pkg::OP_CLEAR, 10'h3FF);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    issue_op(fspa_pkg::OP_FREE, 10'h3FF);
    issue_op(fspa_pkg::OP_FREE, 10'd0);
    issue_op(fspa_pkg::OP_FREE, 10'd0);     // double free
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    set_pool(32'hFFFF_FFFF, 16'hFFFF, 11'd1024);
    issue_op(fspa_pkg::OP_CLEAR, 10'd0);
    issue_op(fspa_pkg::OP_FREE, 10'h3FF);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);    // address wraps
    set_pool(32'hFFFF_FFFF, 16'h0000, 11'd2047);
    issue_op(fspa_pkg::OP_CLEAR, 10'd0);
    issue_op(fspa_pkg::OP_FREE, 10'h3FF);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    issue_op(fspa_pkg::OP_NOP, 10'h3FF);
  endtask

  // a slot freed twice links to itself, so allocate never runs dry
  task automatic test_self_linked_slot();
    idle_on = 1'b0;
    set_pool(32'h0000_1000, 16'hFFFF, 11'd2);
    issue_op(fspa_pkg::OP_CLEAR, 10'd0);
    issue_op(fspa_pkg::OP_ALLOC, 10'd0);
    issue_op(fspa_pkg::OP_FREE, 10'd0);
    issue_op(fspa_pkg::OP_FREE, 10'd0);
    for (int i = 0; i < LOOP_ALLOCS; i++) issue_op(fspa_pkg::OP_ALLOC, 10'($urandom));
    repeat (3) issue_op(fspa_pkg::OP_FREE, 10'd0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int         r;
    int         k;
    logic [9:0] idx;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_pool($urandom, 16'($urandom_range(1, 64)), 11'($urandom_range(1, 6)));
        1: set_pool(32'hFFFF_FFFF, 16'hFFFF, 11'd1024);
        2: set_pool($urandom, 16'h0000, 11'd0);
        3: set_pool($urandom, 16'($urandom), 11'($urandom_range(1, 40)));
        default: set_pool(32'h0000_0000, 16'd1, 11'd2047);
      endcase
      held_slots.delete();
      issue_op(fspa_pkg::OP_CLEAR, 10'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 45) begin
          issue_op(fspa_pkg::OP_ALLOC, 10'($urandom));
        end else if (r < 80) begin
          if (held_slots.size() > 0) begin
            k   = $urandom_range(0, held_slots.size() - 1);
            idx = held_slots[k];
            held_slots.delete(k);
          end else begin
            idx = 10'($urandom_range(0, usable_slots() - 1));
          end
          issue_op(fspa_pkg::OP_FREE, idx);
        end else if (r < 90) begin
          issue_op(fspa_pkg::OP_FREE, 10'($urandom));
        end else if (r < 95) begin
          issue_op(fspa_pkg::OP_NOP, 10'($urandom));
        end else if (r < 97) begin
          held_slots.delete();
          issue_op(fspa_pkg::OP_CLEAR, 10'($urandom));
        end else begin
          issue_op(fspa_pkg::OP_ALLOC, 10'($urandom));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_register_extremes();
    test_self_linked_slot();
    test_random_traffic();
    settle();
    if (alloc_replies.size() != 0) begin
      $error("%0d predicted results never arrived", alloc_replies.size());
      fail_cnt++;
    end
    $display("Ops sent %0d, results checked %0d, allocations granted %0d, refused %0d",
             ops_sent, replies_seen, grants, refusals);
    $display("Covered reset state, register extremes, a self-linked slot and %0d pool settings",
             PHASES);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
